>>> rtl/columnar_block_transposer_assert.svh
// Assertion macros for the columnar block transposer checker.
// Both sample on clk and are disabled while rst_n is low.
`ifndef COLUMNAR_BLOCK_TRANSPOSER_ASSERT_SVH
`define COLUMNAR_BLOCK_TRANSPOSER_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define CBT_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define CBT_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/cbt_pkg.sv
package cbt_pkg;

  // Buffer and grid limits
  localparam int MAX_MESSAGE = 128;
  localparam int MAX_COLUMNS = 16;

  localparam int BYTE_W = 8;
  localparam int COL_W  = 5;
  localparam int CNT_W  = $clog2(MAX_MESSAGE + 1);
  localparam int ADDR_W = $clog2(MAX_MESSAGE);
  localparam int ACC_W  = $clog2(MAX_MESSAGE + MAX_COLUMNS);
  localparam int IDX_W  = ACC_W + 1;

  localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h3A;
  localparam logic [COL_W-1:0]  COL_RESET = 5'd4;

  // Request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // Register indexes
  localparam logic [0:0] REG_COLUMN_COUNT = 1'b0;
  localparam logic [0:0] REG_DIRECTION    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FETCH = 4'b1000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic fetch;
    logic fetch_empty;
    logic fetch_out;
    logic div_step;
    logic div_end;
    logic scan_step;
    logic scan_end;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_avail;
    logic div_done;
    logic inverse;
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/cbt_ctrl.sv
module cbt_ctrl
  import cbt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_kind,
  input  logic in_final,
  input  sts_t sts,
  output logic in_tready,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE) && !sts.out_busy;
  assign accept    = in_tvalid && in_tready;

  // Decode state into datapath commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load = 1'b1;
            if (in_final) begin
              state_nxt = ST_DIV;
            end
          end else if (sts.emit_avail) begin
            cmd.fetch = 1'b1;
            state_nxt = ST_FETCH;
          end else begin
            cmd.fetch_empty = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_end = 1'b1;
          state_nxt   = sts.inverse ? ST_SCAN : ST_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          cmd.scan_end = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FETCH: begin
        cmd.fetch_out = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/cbt_datapath.sv
module cbt_datapath
  import cbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_final,
  input  logic              cfg_valid,
  input  logic [0:0]        cfg_index,
  input  logic [COL_W-1:0]  cfg_data,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [BYTE_W-1:0] out_tdata,
  output logic              out_tlast,
  output logic [1:0]        out_tuser
);

  logic [BYTE_W-1:0] mem [MAX_MESSAGE];
  logic [BYTE_W-1:0] rdata_r;

  // Configuration and latched geometry
  logic [COL_W-1:0] column_count_r;
  logic             direction_r;
  logic [COL_W-1:0] cols_r;
  logic             dir_r;
  logic [COL_W-1:0] col_clamp;

  // Message and emission state
  logic [CNT_W-1:0] cnt_r;
  logic             emitting_r;
  logic             ovf_r;
  logic [ACC_W-1:0] pos_r;
  logic [ACC_W-1:0] total_r;
  logic [CNT_W-1:0] rows_r;
  logic [ACC_W-1:0] acc_r;
  logic [COL_W-1:0] full_r;

  // Grid walk position
  logic [CNT_W-1:0] wr_r;
  logic [COL_W-1:0] wc_r;
  logic [CNT_W-1:0] wstart_r;
  logic [ACC_W-1:0] widx_r;

  // Trim scan stage and fetch stage
  logic             s1_valid_r;
  logic             s1_pad_r;
  logic [ACC_W-1:0] s1_pos1_r;
  logic [ACC_W-1:0] last_r;
  logic             fpad_r;
  logic             ffinal_r;

  // Output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_last_r;
  logic              out_nr_r;
  logic              out_ovf_r;

  logic [CNT_W-1:0]  load_base;
  logic              room;
  logic [IDX_W-1:0]  inv_idx;
  logic [IDX_W-1:0]  cur_idx;
  logic              beyond;
  logic              inv_pad;
  logic              cell_pad;
  logic [ADDR_W-1:0] raddr;
  logic              last_row;
  logic [COL_W:0]    wc_inc;
  logic              scan_issue;
  logic              walk_step;
  logic              walk_reset;
  logic [ACC_W:0]    pos_inc;

  // Loads after an abandoned output start from an empty buffer
  assign load_base = emitting_r ? '0 : cnt_r;
  assign room      = load_base < CNT_W'(MAX_MESSAGE);

  // Clamp the configured width into the supported range
  always_comb begin
    if (column_count_r == '0) begin
      col_clamp = COL_W'(1);
    end else if (int'(column_count_r) > MAX_COLUMNS) begin
      col_clamp = COL_W'(MAX_COLUMNS);
    end else begin
      col_clamp = column_count_r;
    end
  end

  // Buffer index of the current grid cell and its pad condition
  assign inv_idx  = IDX_W'(wstart_r) + IDX_W'(wr_r);
  assign cur_idx  = dir_r ? inv_idx : IDX_W'(widx_r);
  assign beyond   = cur_idx >= IDX_W'(cnt_r);
  assign last_row = (CNT_W + 1)'(wr_r) + 1'b1 >= (CNT_W + 1)'(rows_r);
  assign inv_pad  = last_row && (wc_r >= full_r);
  assign cell_pad = beyond || (dir_r && inv_pad);
  assign raddr    = cur_idx[ADDR_W-1:0];
  assign wc_inc   = {1'b0, wc_r} + 1'b1;

  assign scan_issue = pos_r != ACC_W'(cnt_r);
  assign walk_step  = cmd.fetch || (cmd.scan_step && scan_issue);
  assign walk_reset = cmd.div_end || cmd.scan_end;
  assign pos_inc    = {1'b0, pos_r} + 1'b1;

  assign sts.emit_avail = emitting_r && (pos_r < total_r);
  assign sts.div_done   = acc_r >= ACC_W'(cnt_r);
  assign sts.inverse    = dir_r;
  assign sts.scan_done  = !scan_issue && !s1_valid_r;
  assign sts.out_busy   = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_nr_r};

  // Message buffer: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem[load_base[ADDR_W-1:0]] <= in_byte;
    end
    rdata_r <= mem[raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= COL_RESET;
      direction_r    <= 1'b0;
      cols_r         <= COL_W'(1);
      dir_r          <= 1'b0;
      cnt_r          <= '0;
      emitting_r     <= 1'b0;
      ovf_r          <= 1'b0;
      pos_r          <= '0;
      total_r        <= '0;
      rows_r         <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      // Register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_COLUMN_COUNT: column_count_r <= cfg_data;
          REG_DIRECTION:    direction_r    <= cfg_data[0];
        endcase
      end

      // Load one byte, abandoning any pending output
      if (cmd.load) begin
        if (emitting_r) begin
          emitting_r <= 1'b0;
          pos_r      <= '0;
          total_r    <= '0;
        end
        if (load_base == '0) begin
          ovf_r <= 1'b0;
        end
        if (room) begin
          cnt_r <= load_base + 1'b1;
        end else begin
          cnt_r <= load_base;
          ovf_r <= 1'b1;
        end
        if (in_final) begin
          cols_r <= col_clamp;
          dir_r  <= direction_r;
          rows_r <= '0;
        end
      end

      // Count rows
      if (cmd.div_step) begin
        rows_r <= rows_r + 1'b1;
      end
      if (cmd.div_end) begin
        pos_r <= '0;
        if (!dir_r) begin
          total_r    <= acc_r;
          emitting_r <= 1'b1;
        end
      end

      // Trim scan issue stage
      if (cmd.scan_step) begin
        s1_valid_r <= scan_issue;
        if (scan_issue) begin
          pos_r <= pos_inc[ACC_W-1:0];
        end
      end
      if (cmd.scan_end) begin
        pos_r   <= '0;
        total_r <= last_r;
        if (last_r == '0) begin
          emitting_r <= 1'b0;
          cnt_r      <= '0;
        end else begin
          emitting_r <= 1'b1;
        end
      end

      // Advance emission; the buffer empties after the last byte
      if (cmd.fetch) begin
        pos_r <= pos_inc[ACC_W-1:0];
        if (pos_inc >= {1'b0, total_r}) begin
          emitting_r <= 1'b0;
          cnt_r      <= '0;
        end
      end

      // Output register: hold until taken
      if (cmd.fetch_out || cmd.fetch_empty) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (cmd.load && in_final) begin
      acc_r <= '0;
    end else if (cmd.div_step) begin
      acc_r <= acc_r + ACC_W'(cols_r);
    end

    if (cmd.div_end) begin
      full_r <= COL_W'(ACC_W'(cnt_r) + ACC_W'(cols_r) - acc_r);
      last_r <= '0;
    end

    // Walk the grid one cell at a time
    if (walk_reset) begin
      wr_r     <= '0;
      wc_r     <= '0;
      wstart_r <= '0;
      widx_r   <= '0;
    end else if (walk_step) begin
      if (!dir_r) begin
        if (last_row) begin
          wr_r   <= '0;
          wc_r   <= wc_inc[COL_W-1:0];
          widx_r <= ACC_W'(wc_inc);
        end else begin
          wr_r   <= wr_r + 1'b1;
          widx_r <= widx_r + ACC_W'(cols_r);
        end
      end else begin
        if (wc_inc == {1'b0, cols_r}) begin
          wc_r     <= '0;
          wr_r     <= wr_r + 1'b1;
          wstart_r <= '0;
        end else begin
          wc_r <= wc_inc[COL_W-1:0];
          if (wc_inc <= {1'b0, full_r}) begin
            wstart_r <= wstart_r + rows_r;
          end else begin
            wstart_r <= wstart_r + rows_r - 1'b1;
          end
        end
      end
    end

    // Trim scan: remember the end of the last non-pad cell
    if (cmd.scan_step && scan_issue) begin
      s1_pad_r  <= cell_pad;
      s1_pos1_r <= pos_inc[ACC_W-1:0];
    end
    if (s1_valid_r && !s1_pad_r && (rdata_r != PAD_BYTE)) begin
      last_r <= s1_pos1_r;
    end

    // Fetch stage
    if (cmd.fetch) begin
      fpad_r   <= cell_pad;
      ffinal_r <= pos_inc == {1'b0, total_r};
    end

    if (cmd.fetch_out) begin
      out_data_r <= fpad_r ? PAD_BYTE : rdata_r;
      out_last_r <= ffinal_r;
      out_nr_r   <= 1'b0;
      out_ovf_r  <= ovf_r;
    end else if (cmd.fetch_empty) begin
      out_data_r <= '0;
      out_last_r <= 1'b0;
      out_nr_r   <= 1'b1;
      out_ovf_r  <= ovf_r;
    end
  end

endmodule

>>> rtl/columnar_block_transposer.sv
// Columnar block transposer.
// Input stream: in_tuser selects a load (0) or a fetch (1) request. A load
// stores in_tdata into the message buffer; in_tlast marks the final byte.
// Each fetch returns one output request: out_tdata is the next byte,
// out_tlast marks the last byte, out_tuser[0] says nothing was pending and
// out_tuser[1] says the message was cut at the buffer size.
// Configuration: cfg_index 0 column count, 1 direction; always ready. The
// values are latched when the final byte loads.
// Timing: a fetch with nothing pending answers in the next cycle; a fetch that
// emits a byte first passes ST_FETCH for the registered buffer read. After the
// final byte the row count loop runs; in inverse mode a trailing-pad scan
// follows, one buffer read per cycle. in_tready is low during these passes.
// Reset empties the buffer state and sets column count 4, direction 0.
// When the receiver stalls, the output register holds its request and
// in_tready stays low until it is taken.
module columnar_block_transposer
  import cbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] byte_in
  input  logic              in_tlast,
  input  logic              in_tuser,   // [0] kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,  // [7:0] byte_out
  output logic              out_tlast,
  output logic [1:0]        out_tuser,  // [0] nothing_ready, [1] overflowed
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [COL_W-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_final  (in_tlast),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  cbt_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_tdata),
    .in_final   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/cbt_checker.sv
`include "columnar_block_transposer_assert.svh"

module cbt_checker
  import cbt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [BYTE_W-1:0] out_tdata,
  input logic              out_tlast,
  input logic [1:0]        out_tuser
);

  // An empty answer carries a zero byte and no last flag
  `CBT_ASSERT_IMP(a_empty_clean, out_tvalid && out_tuser[0], out_tdata == '0 && !out_tlast)

  // A stalled output request holds
  `CBT_ASSERT_NXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // No new request is taken while the output is stalled
  `CBT_ASSERT_IMP(a_stall_blocks, out_tvalid && !out_tready, !in_tready)

  // A load produces no output
  `CBT_ASSERT_NXT(a_load_silent, in_tvalid && in_tready && in_tuser == KIND_LOAD && !out_tvalid, !out_tvalid)

  // A fetch either answers next cycle or holds the input while reading
  `CBT_ASSERT_NXT(a_fetch_answers, in_tvalid && in_tready && in_tuser == KIND_FETCH, out_tvalid || !in_tready)

endmodule

bind columnar_block_transposer cbt_checker u_cbt_checker (.*);

>>> tb/columnar_block_transposer_test.sv
`timescale 1ns / 1ps

module columnar_block_transposer_test;
  import cbt_pkg::*;

  localparam int SETTLE_CYCLES  = 300;   // row count pass plus inverse pad scan, worst case
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEM_TARGET    = 620;   // directed rows plus random requests

  // One result beat: byte, last marker, nothing-pending flag, overflow flag
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              nothing;
    logic              cut;
  } beat_t;

  typedef struct {
    bit    typed;
    beat_t want;
  } tag_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_FETCH, ROW_SET} row_op_t;

  typedef struct {
    row_op_t           op;
    logic [0:0]        regsel;
    logic [BYTE_W-1:0] value;
    logic              fin;
    bit                typed;
    beat_t             want;
  } plan_row_t;

  localparam beat_t IDLE_BEAT = '{data: 8'h00, last: 1'b0, nothing: 1'b1, cut: 1'b0};
  localparam int PLAN_LEN = 31;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              in_tuser   = KIND_LOAD;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [BYTE_W-1:0] out_tdata;
  logic              out_tlast;
  logic [1:0]        out_tuser;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [0:0]        cfg_index  = REG_COLUMN_COUNT;
  logic [COL_W-1:0]  cfg_data   = '0;

  columnar_block_transposer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Transposer state as the block should hold it
  logic [BYTE_W-1:0] msg_buf [MAX_MESSAGE];
  int  held_count = 0;
  int  emit_pos   = 0;
  int  emit_len   = 0;
  int  row_len    = 0;
  bit  emitting_q = 1'b0;
  bit  cut_seen   = 1'b0;
  int  col_reg    = int'(COL_RESET);
  bit  dir_reg    = 1'b0;
  int  grid_c     = 1;
  bit  grid_inv   = 1'b0;

  beat_t beat_q [$];
  tag_t  tag_q [$];
  int    err_count   = 0;
  int    items_sent  = 0;
  int    burst_left  = 0;
  int    idle_cycles = 0;
  int    stall_mode  = 0;
  int    mode_left   = 0;

  // Byte at output position pos of the latched grid
  function automatic logic [BYTE_W-1:0] grid_at(int pos);
    int r, c, idx, full, start;
    if (row_len == 0) return PAD_BYTE;
    if (!grid_inv) begin
      c   = pos / row_len;
      r   = pos % row_len;
      idx = r * grid_c + c;
    end else begin
      full = held_count % grid_c;
      if (full == 0) full = grid_c;
      r = pos / grid_c;
      c = pos % grid_c;
      // short trailing columns have no cell in the last row
      if (r + 1 >= row_len && c >= full) return PAD_BYTE;
      start = (c <= full) ? c * row_len : c * row_len - (c - full);
      idx   = start + r;
    end
    if (idx < held_count && idx < MAX_MESSAGE) return msg_buf[idx];
    return PAD_BYTE;
  endfunction

  // Latch the geometry and size the output once the final byte lands
  function automatic void seal_message();
    int t;
    if (col_reg == 0) grid_c = 1;
    else if (col_reg > MAX_COLUMNS) grid_c = MAX_COLUMNS;
    else grid_c = col_reg;
    grid_inv = dir_reg;
    row_len  = (held_count + grid_c - 1) / grid_c;
    if (!grid_inv) begin
      emit_len = row_len * grid_c;
    end else begin
      // drop every trailing pad, genuine colons included
      t = held_count;
      while (t > 0 && grid_at(t - 1) == PAD_BYTE) t--;
      emit_len = t;
    end
    emit_pos = 0;
    if (emit_len == 0) begin
      emitting_q = 1'b0;
      held_count = 0;
    end else begin
      emitting_q = 1'b1;
    end
  endfunction

  // Advance the transposer by one request; returns 1 when a result is due
  function automatic bit transpose_step(input logic kind, input logic [BYTE_W-1:0] b,
                                        input logic fin, output beat_t res);
    res = IDLE_BEAT;
    if (kind == KIND_LOAD) begin
      // a load while emitting abandons the rest of the output
      if (emitting_q) begin
        emitting_q = 1'b0;
        held_count = 0;
        emit_pos   = 0;
        emit_len   = 0;
      end
      if (held_count == 0) cut_seen = 1'b0;
      if (held_count < MAX_MESSAGE) begin
        msg_buf[held_count] = b;
        held_count++;
      end else begin
        cut_seen = 1'b1;
      end
      if (fin) seal_message();
      return 1'b0;
    end
    res.cut = cut_seen;
    if (!emitting_q || emit_pos >= emit_len) return 1'b1;
    res.data    = grid_at(emit_pos);
    res.last    = (emit_pos + 1 == emit_len);
    res.nothing = 1'b0;
    emit_pos++;
    if (emit_pos >= emit_len) begin
      emitting_q = 1'b0;
      held_count = 0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got 0x%0h want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Track register writes and predict on every accepted request
  always @(posedge clk) begin
    tag_t  tag;
    beat_t res;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_COLUMN_COUNT) col_reg = int'(cfg_data);
        else dir_reg = cfg_data[0];
      end
      if (in_tvalid && in_tready) begin
        tag = tag_q.pop_front();
        if (transpose_step(in_tuser, in_tdata, in_tlast, res))
          beat_q.insert(beat_q.size(), tag.typed ? tag.want : res);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (beat_q.size() == 0) begin
        report_mismatch("unsolicited result byte", int'(out_tdata), 0);
      end else begin
        want = beat_q.pop_front();
        if (out_tdata !== want.data)
          report_mismatch("byte_out", int'(out_tdata), int'(want.data));
        if (out_tlast !== want.last)
          report_mismatch("final_out", int'(out_tlast), int'(want.last));
        if (out_tuser[0] !== want.nothing)
          report_mismatch("nothing_ready", int'(out_tuser[0]), int'(want.nothing));
        if (out_tuser[1] !== want.cut)
          report_mismatch("overflowed", int'(out_tuser[1]), int'(want.cut));
      end
    end
  end

  // Receiver: switch between always ready, coin flip and mostly stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(30, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("columnar_block_transposer_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request, with bursts and random gaps, and hold until accepted
  task automatic send_request(input logic kind, input logic [BYTE_W-1:0] value,
                              input logic fin, input bit typed, input beat_t want);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    tag_q.insert(tag_q.size(), '{typed: typed, want: want});
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Leave cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [0:0] idx, input logic [COL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Hold off until every result is back and the end-of-message passes are over
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (beat_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // One message of random bytes, then fetches for its output
  task automatic run_message(input int eff_cols, input bit eff_inv, input bit force_cut);
    int r, len, stored, fetches;
    bit all_pad;
    logic [BYTE_W-1:0] b;
    r = $urandom_range(0, 99);
    if (force_cut || r >= 96) len = $urandom_range(MAX_MESSAGE + 1, MAX_MESSAGE + 6);
    else if (r >= 91) len = $urandom_range(81, MAX_MESSAGE);
    else if (r >= 72) len = $urandom_range(25, 80);
    else len = $urandom_range(1, 24);
    all_pad = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < len; k++) begin
      // stray fetch while loading
      if ($urandom_range(0, 19) == 0)
        send_request(KIND_FETCH, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, IDLE_BEAT);
      if (all_pad || $urandom_range(0, 3) == 0) b = PAD_BYTE;
      else b = 8'($urandom);
      send_request(KIND_LOAD, b, k == len - 1, 1'b0, IDLE_BEAT);
    end
    stored  = (len > MAX_MESSAGE) ? MAX_MESSAGE : len;
    fetches = eff_inv ? stored : ((stored + eff_cols - 1) / eff_cols) * eff_cols;
    // sometimes stop early so the next load abandons the output
    if ($urandom_range(0, 7) == 0) fetches = $urandom_range(0, fetches);
    else fetches += $urandom_range(0, 2);
    repeat (fetches)
      send_request(KIND_FETCH, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, IDLE_BEAT);
  endtask

  plan_row_t plan [PLAN_LEN] = '{
    // fetch right after reset: nothing pending
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b1, IDLE_BEAT},
    // byte extremes, four columns forward, short row padded
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'hFF, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'h3A, 1'b1, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'hFF, 1'b1, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h55, 1'b1, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'hAA, 1'b0, 1'b0, IDLE_BEAT},
    // output spent
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b1, IDLE_BEAT},
    // zero columns act as one, inverse; message of pads only trims to nothing
    '{ROW_SET,   REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_SET,   REG_DIRECTION,    8'h01, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'h3A, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'h3A, 1'b1, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b1, IDLE_BEAT},
    // column count above the limit saturates, inverse
    '{ROW_SET,   REG_COLUMN_COUNT, 8'h1F, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'h41, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'h3A, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'h42, 1'b1, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b0, IDLE_BEAT},
    // load while emitting abandons the rest and starts a new message
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'h7E, 1'b1, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b1, IDLE_BEAT},
    // back to forward with three columns
    '{ROW_SET,   REG_DIRECTION,    8'h00, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_SET,   REG_COLUMN_COUNT, 8'h03, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'h5C, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_LOAD,  REG_COLUMN_COUNT, 8'hC5, 1'b1, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b0, IDLE_BEAT},
    '{ROW_FETCH, REG_COLUMN_COUNT, 8'h00, 1'b0, 1'b1, IDLE_BEAT}
  };

  initial begin
    int r, cols, eff_cols, msg_no;
    bit dir;
    msg_no = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      case (plan[i].op)
        ROW_SET: begin
          if (plan[i - 1].op != ROW_SET) quiesce();
          write_reg(plan[i].regsel, plan[i].value[COL_W-1:0]);
          if (i + 1 >= PLAN_LEN || plan[i + 1].op != ROW_SET) cfg_valid <= 1'b0;
        end
        ROW_LOAD:
          send_request(KIND_LOAD, plan[i].value, plan[i].fin, plan[i].typed, plan[i].want);
        default:
          send_request(KIND_FETCH, plan[i].value, plan[i].fin, plan[i].typed, plan[i].want);
      endcase
    end

    // Random phases: drain, set geometry, run a few messages
    while (items_sent < ITEM_TARGET) begin
      quiesce();
      r = $urandom_range(0, 9);
      case (r)
        0: cols = 0;
        1: cols = 31;
        2: cols = MAX_COLUMNS;
        3: cols = 1;
        4: cols = $urandom_range(MAX_COLUMNS + 1, 30);
        default: cols = $urandom_range(2, MAX_COLUMNS - 1);
      endcase
      dir = 1'($urandom_range(0, 1));
      write_reg(REG_COLUMN_COUNT, cols[COL_W-1:0]);
      write_reg(REG_DIRECTION, {{(COL_W-1){1'b0}}, dir});
      cfg_valid <= 1'b0;
      if (cols == 0) eff_cols = 1;
      else if (cols > MAX_COLUMNS) eff_cols = MAX_COLUMNS;
      else eff_cols = cols;
      repeat ($urandom_range(1, 4)) begin
        if (items_sent < ITEM_TARGET) begin
          run_message(eff_cols, dir, msg_no == 2);
          msg_no++;
        end
      end
    end

    quiesce();
    if (err_count == 0) begin
      $display("columnar_block_transposer_test: clean");
    end else begin
      $display("columnar_block_transposer_test: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cbt_pkg.sv
rtl/cbt_ctrl.sv
rtl/cbt_datapath.sv
rtl/columnar_block_transposer.sv
rtl/cbt_checker.sv
tb/columnar_block_transposer_test.sv
